### src/rsc_pkg.sv
package rsc_pkg;

    localparam int LETTERS     = 26;
    localparam int ROTOR_KINDS = 5;

    // A letter index, A = 0 up to Z = 25.
    typedef logic [4:0] letter_t;

    // Rotor selector, where codes above the last rotor mean a straight-through wheel.
    typedef logic [2:0] rotor_sel_t;

    // Register index on the configuration port.
    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_MODE         = 3'd0;
    localparam reg_index_t REG_FIRST_ROTOR  = 3'd1;
    localparam reg_index_t REG_SECOND_ROTOR = 3'd2;
    localparam reg_index_t REG_THIRD_ROTOR  = 3'd3;
    localparam reg_index_t REG_START_SHIFT  = 3'd4;

    // Mode codes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Character codes used by the case folding and the letter test.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Fixed rotor wirings, first character in the most significant byte.
    localparam logic [LETTERS*8-1:0] ROTOR_WIRING [ROTOR_KINDS] = '{
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK"
    };

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic       mode;
        rotor_sel_t first_rotor;
        rotor_sel_t second_rotor;
        rotor_sel_t third_rotor;
        letter_t    shift;
    } rsc_cfg_t;

    // Forward pass of one rotor.
    function automatic letter_t rotor_fwd(input rotor_sel_t sel, input letter_t p);
        letter_t    res;
        logic [7:0] wch;
        res = p;
        if (sel < rotor_sel_t'(ROTOR_KINDS)) begin
            for (int k = 0; k < LETTERS; k++) begin
                wch = ROTOR_WIRING[sel][8*(LETTERS-1-k) +: 8];
                if (p == letter_t'(k)) begin
                    res = letter_t'(wch - CHAR_UPPER_A);
                end
            end
        end
        return res;
    endfunction

    // Reverse pass of one rotor: the position whose wiring gives this letter.
    function automatic letter_t rotor_back(input rotor_sel_t sel, input letter_t c);
        letter_t    res;
        logic [7:0] wch;
        res = c;
        if (sel < rotor_sel_t'(ROTOR_KINDS)) begin
            for (int k = 0; k < LETTERS; k++) begin
                wch = ROTOR_WIRING[sel][8*(LETTERS-1-k) +: 8];
                if (letter_t'(wch - CHAR_UPPER_A) == c) begin
                    res = letter_t'(k);
                end
            end
        end
        return res;
    endfunction

    // Sum of two letter indices modulo 26.
    function automatic letter_t add_mod(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'(LETTERS)) begin
            s = s - 6'(LETTERS);
        end
        return s[4:0];
    endfunction

    // Difference of two letter indices modulo 26.
    function automatic letter_t sub_mod(input letter_t a, input letter_t b);
        logic [5:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end
        else begin
            s = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
        end
        return s[4:0];
    endfunction

endpackage

### src/rsc_datapath.sv
module rsc_datapath (
    input  rsc_pkg::rsc_cfg_t cfg,
    input  rsc_pkg::letter_t  count,
    input  logic [7:0]        char_in,
    output logic [7:0]        char_out,
    output logic              is_letter
);
    import rsc_pkg::*;

    logic [7:0] folded;
    letter_t    p;
    letter_t    off;
    letter_t    shifted;
    letter_t    enc_1;
    letter_t    enc_2;
    letter_t    enc_3;
    letter_t    dec_1;
    letter_t    dec_2;
    letter_t    dec_3;
    letter_t    result;

    // Fold lower case onto upper case and test for a letter.
    always_comb
    begin
        if (char_in >= CHAR_LOWER_A && char_in <= CHAR_LOWER_Z) begin
            folded = char_in - CASE_OFFSET;
        end
        else begin
            folded = char_in;
        end
        is_letter = (folded >= CHAR_UPPER_A) && (folded <= CHAR_UPPER_Z);
        p         = letter_t'(folded - CHAR_UPPER_A);
    end

    // The rotating offset combines the start shift with the letter count.
    assign off = add_mod(cfg.shift, count);

    // Encode: shift, then the three rotors in order.
    assign shifted = add_mod(p, off);
    assign enc_1   = rotor_fwd(cfg.first_rotor, shifted);
    assign enc_2   = rotor_fwd(cfg.second_rotor, enc_1);
    assign enc_3   = rotor_fwd(cfg.third_rotor, enc_2);

    // Decode: inverse rotors in reverse order, then remove the shift.
    assign dec_1 = rotor_back(cfg.third_rotor, p);
    assign dec_2 = rotor_back(cfg.second_rotor, dec_1);
    assign dec_3 = rotor_back(cfg.first_rotor, dec_2);

    assign result = (cfg.mode == MODE_DECODE) ? sub_mod(dec_3, off) : enc_3;

    // Letters leave as upper case; everything else passes unchanged.
    assign char_out = is_letter ? (CHAR_UPPER_A + {3'b000, result}) : folded;

endmodule

### src/rotor_substitution_cipher.sv
// Path: an accepted request is captured in the input register and then in the output
// register, from which it is offered on out_valid.
// Throughput: one character per cycle while the output side is not stalled; the input register and the output register
// form a two-entry pipeline, so input is taken into a free input register while a finished result waits.
// Reset: asynchronous, active low; clears both pipeline stages, the letter count and
// restores the configuration to encode with rotors 0, 1, 2 and no start shift.
module rotor_substitution_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  rsc_pkg::reg_index_t cfg_index,
    input  logic [4:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_char
);
    import rsc_pkg::*;

    logic       mode_reg;
    rotor_sel_t first_rotor_reg;
    rotor_sel_t second_rotor_reg;
    rotor_sel_t third_rotor_reg;
    letter_t    shift_reg;
    letter_t    shift_next;
    letter_t    count_reg;
    letter_t    count_next;

    logic       stage_valid_reg;
    logic [7:0] stage_char_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;

    logic       in_accept;
    logic       stage_advance;
    rsc_cfg_t   cfg;
    logic [7:0] sub_char;
    logic       sub_letter;

    // Configuration registers; the start shift is kept already reduced modulo 26.
    assign shift_next = (cfg_data >= 5'(LETTERS)) ? cfg_data - 5'(LETTERS) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= MODE_ENCODE;
            first_rotor_reg  <= 3'd0;
            second_rotor_reg <= 3'd1;
            third_rotor_reg  <= 3'd2;
            shift_reg        <= '0;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_MODE:         mode_reg         <= cfg_data[0];
                REG_FIRST_ROTOR:  first_rotor_reg  <= cfg_data[2:0];
                REG_SECOND_ROTOR: second_rotor_reg <= cfg_data[2:0];
                REG_THIRD_ROTOR:  third_rotor_reg  <= cfg_data[2:0];
                REG_START_SHIFT:  shift_reg        <= shift_next;
                default:          ;
            endcase
        end
    end

    assign cfg = '{
        mode:         mode_reg,
        first_rotor:  first_rotor_reg,
        second_rotor: second_rotor_reg,
        third_rotor:  third_rotor_reg,
        shift:        shift_reg
    };

    // Flow control: the input stage moves on whenever the output register is free.
    assign stage_advance = !out_valid_reg || out_ready;
    assign in_ready      = !stage_valid_reg || stage_advance;
    assign in_accept     = in_valid && in_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            stage_char_reg <= in_char;
        end
    end

    // Substitution for the character held in the input register.
    rsc_datapath u_datapath (
        .cfg       (cfg),
        .count     (count_reg),
        .char_in   (stage_char_reg),
        .char_out  (sub_char),
        .is_letter (sub_letter)
    );

    // Letter count steps once for each letter that leaves the input register.
    assign count_next = (count_reg == letter_t'(LETTERS - 1)) ? '0 : count_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (stage_advance) begin
            out_valid_reg <= stage_valid_reg;
            if (stage_valid_reg && sub_letter) begin
                count_reg <= count_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (stage_advance && stage_valid_reg) begin
            out_char_reg <= sub_char;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;

endmodule

### src/rsc_checker.sv
module rsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char
);
    import rsc_pkg::*;

    // A result never carries a lower-case letter, since letters are folded.
    a_no_lower_case: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_char >= CHAR_LOWER_A && out_char <= CHAR_LOWER_Z))
        else $error("lower-case letter on the output");

    // With the output register empty the block must take a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while the output is empty");

    // Once a taken request has passed both registers, a result is on offer.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("no result two cycles after a request");

    // A stalled result is held.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char)))
        else $error("stalled result dropped or changed");

endmodule

bind rotor_substitution_cipher rsc_checker u_rsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char)
);
